// ===== rtl/cea608pe_pkg.sv =====
package cea608pe_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_CONTROL_HIGH  = 2'd0;
  localparam logic [1:0] REG_RESUME_LOW    = 2'd1;
  localparam logic [1:0] REG_END_LOW       = 2'd2;
  localparam logic [1:0] REG_ERASE_LOW     = 2'd3;

  localparam logic [6:0] CONTROL_HIGH_RST  = 7'd20;
  localparam logic [6:0] RESUME_LOW_RST    = 7'd32;
  localparam logic [6:0] END_LOW_RST       = 7'd47;
  localparam logic [6:0] ERASE_LOW_RST     = 7'd46;

  localparam logic [6:0] CHAR_SPACE        = 7'h20;
  localparam logic [7:0] NULL_PAD          = 8'h80;
  localparam logic [6:0] INDENT_FLAG       = 7'h10;

  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 16;

  typedef struct packed {
    logic [6:0] hi;
    logic [6:0] lo;
  } pac_t;

  // Adds odd parity in bit 7.
  function automatic logic [7:0] with_parity(input logic [6:0] b);
    return {~^b, b};
  endfunction

  // Preamble address code for a row already clamped to 1..15.
  function automatic pac_t pac_row(input logic [3:0] row);
    pac_t p;
    p.hi = 7'h11;
    p.lo = 7'h40;
    case (row)
      4'd1:  begin p.hi = 7'h11; p.lo = 7'h40; end
      4'd2:  begin p.hi = 7'h11; p.lo = 7'h60; end
      4'd3:  begin p.hi = 7'h12; p.lo = 7'h40; end
      4'd4:  begin p.hi = 7'h12; p.lo = 7'h60; end
      4'd5:  begin p.hi = 7'h15; p.lo = 7'h40; end
      4'd6:  begin p.hi = 7'h15; p.lo = 7'h60; end
      4'd7:  begin p.hi = 7'h16; p.lo = 7'h40; end
      4'd8:  begin p.hi = 7'h16; p.lo = 7'h60; end
      4'd9:  begin p.hi = 7'h17; p.lo = 7'h40; end
      4'd10: begin p.hi = 7'h17; p.lo = 7'h60; end
      4'd11: begin p.hi = 7'h10; p.lo = 7'h40; end
      4'd12: begin p.hi = 7'h13; p.lo = 7'h40; end
      4'd13: begin p.hi = 7'h13; p.lo = 7'h60; end
      4'd14: begin p.hi = 7'h14; p.lo = 7'h40; end
      4'd15: begin p.hi = 7'h14; p.lo = 7'h60; end
      default: begin p.hi = 7'h11; p.lo = 7'h40; end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/cea608_popon_pair_encoder_unit.sv =====
// Pop-on caption encoder producing CEA-608 channel-one byte pairs with odd
// parity. An item is taken into an input register and its pairs leave through
// a single output register, one pair per cycle: a start-cue item yields three
// pairs, an end-cue item one or two, and a character item one (the first
// character of a pair produces nothing and is held internally).
// A new item is accepted in the cycle its predecessor's last pair is loaded,
// so output back-pressure is the only thing that slows the flow further.
// Configuration writes are always accepted and should only be made while idle.
module cea608_popon_pair_encoder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // char_code [15:0], cue_row [19:16], cue_column [24:20], zero [31:25]
  input  logic [cea608pe_pkg::TDATA_IN_W-1:0]  in_tdata,
  // command [1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pair_word [15:0]
  output logic [cea608pe_pkg::TDATA_OUT_W-1:0] out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [6:0]                         cfg_data
);
  import cea608pe_pkg::*;

  logic [6:0]  ctrl_hi_r, rcl_lo_r, eoc_lo_r, enm_lo_r;

  logic        stg_valid_r;
  cmd_t        stg_cmd_r;
  logic [6:0]  stg_char_r;
  logic [3:0]  stg_row_r;
  logic [2:0]  stg_step_r;
  logic [1:0]  stg_k_r, stg_k_nxt;

  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;

  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  logic [1:0]  n_words;
  logic [15:0] w0, w1, w2, w_sel;
  logic [7:0]  char_byte;
  pac_t        pac;
  logic [6:0]  pac_lo;
  logic        out_free, load_word, word_last, stg_done, in_acc;
  logic [6:0]  in_char;
  logic [15:0] in_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_hi_r <= CONTROL_HIGH_RST;
      rcl_lo_r  <= RESUME_LOW_RST;
      eoc_lo_r  <= END_LOW_RST;
      enm_lo_r  <= ERASE_LOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONTROL_HIGH: ctrl_hi_r <= cfg_data;
        REG_RESUME_LOW:   rcl_lo_r  <= cfg_data;
        REG_END_LOW:      eoc_lo_r  <= cfg_data;
        REG_ERASE_LOW:    enm_lo_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Codes outside the printable range are replaced by a space on entry.
  assign in_code = in_tdata[15:0];
  assign in_char = (in_code[15:7] != 9'd0 || in_code[6:5] == 2'b00) ? CHAR_SPACE
                                                                     : in_code[6:0];

  assign char_byte = with_parity(stg_char_r);
  assign pac       = pac_row(stg_row_r);
  assign pac_lo    = (stg_step_r != 3'd0) ? (pac.lo | INDENT_FLAG | {3'd0, stg_step_r, 1'b0})
                                          : pac.lo;

  always_comb begin
    n_words = 2'd0;
    w0 = '0;
    w1 = '0;
    w2 = '0;
    case (stg_cmd_r)
      CMD_START: begin
        n_words = 2'd3;
        w0 = {with_parity(ctrl_hi_r), with_parity(enm_lo_r)};
        w1 = {with_parity(ctrl_hi_r), with_parity(rcl_lo_r)};
        w2 = {with_parity(pac.hi), with_parity(pac_lo)};
      end
      CMD_CHAR: begin
        n_words = pend_valid_r ? 2'd1 : 2'd0;
        w0 = {pend_byte_r, char_byte};
      end
      CMD_END: begin
        if (pend_valid_r) begin
          n_words = 2'd2;
          w0 = {pend_byte_r, NULL_PAD};
          w1 = {with_parity(ctrl_hi_r), with_parity(eoc_lo_r)};
        end else begin
          n_words = 2'd1;
          w0 = {with_parity(ctrl_hi_r), with_parity(eoc_lo_r)};
        end
      end
      default: n_words = 2'd0;
    endcase
  end

  always_comb begin
    case (stg_k_r)
      2'd0:    w_sel = w0;
      2'd1:    w_sel = w1;
      2'd2:    w_sel = w2;
      default: w_sel = w2;
    endcase
  end

  assign out_free  = !out_valid_r || out_tready;
  assign word_last = (stg_k_r == n_words - 2'd1);
  assign load_word = stg_valid_r && (n_words != 2'd0) && out_free;
  assign stg_done  = stg_valid_r && ((n_words == 2'd0) || (out_free && word_last));
  assign in_tready = !stg_valid_r || stg_done;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    stg_k_nxt = stg_k_r;
    if (stg_done) begin
      stg_k_nxt = 2'd0;
    end else if (load_word) begin
      stg_k_nxt = stg_k_r + 2'd1;
    end
  end

  // The held character changes only when its item leaves the input register.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    if (stg_done) begin
      case (stg_cmd_r)
        CMD_START, CMD_END: begin
          pend_valid_nxt = 1'b0;
          pend_byte_nxt  = 8'd0;
        end
        CMD_CHAR: begin
          pend_valid_nxt = !pend_valid_r;
          pend_byte_nxt  = pend_valid_r ? 8'd0 : char_byte;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      stg_k_r      <= 2'd0;
      pend_valid_r <= 1'b0;
      pend_byte_r  <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      stg_k_r      <= stg_k_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_byte_r  <= pend_byte_nxt;
      if (in_acc) begin
        stg_valid_r <= 1'b1;
      end else if (stg_done) begin
        stg_valid_r <= 1'b0;
      end
      if (load_word) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_cmd_r  <= cmd_t'(in_tuser);
      stg_char_r <= in_char;
      stg_row_r  <= (in_tdata[19:16] == 4'd0) ? 4'd1 : in_tdata[19:16];
      stg_step_r <= in_tdata[24:22];
    end
    if (load_word) begin
      out_data_r <= w_sel;
      out_last_r <= word_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    stg_k_r != 2'd3)
    else $error("word index beyond three");

  a_k_restart: assert property (@(posedge clk) disable iff (!rst_n)
    stg_done |=> stg_k_r == 2'd0)
    else $error("word index not cleared after item");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_done && stg_cmd_r == CMD_START) |=> !pend_valid_r)
    else $error("held character survives a start-cue");

  a_load_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_word |=> out_valid_r && out_last_r == $past(word_last))
    else $error("pair not loaded into output register");

endmodule

// ===== test/cea608_popon_pair_encoder_unit_tb.sv =====
module cea608_popon_pair_encoder_unit_tb;
  import cea608pe_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } caption_pair_t;

  // Predicts the byte pairs of the encoder and checks them in order.
  class pair_scoreboard;
    logic [6:0]    ctrl_hi;
    logic [6:0]    rcl_lo;
    logic [6:0]    eoc_lo;
    logic [6:0]    enm_lo;
    bit            held;
    logic [7:0]    held_byte;
    logic [6:0]    pac_hi [15];
    logic [6:0]    pac_lo [15];
    caption_pair_t pairs_due [$];
    int            errors;

    function new();
      ctrl_hi   = CONTROL_HIGH_RST;
      rcl_lo    = RESUME_LOW_RST;
      eoc_lo    = END_LOW_RST;
      enm_lo    = ERASE_LOW_RST;
      held      = 1'b0;
      held_byte = 8'h00;
      errors    = 0;
      pac_hi = '{7'h11, 7'h11, 7'h12, 7'h12, 7'h15, 7'h15, 7'h16, 7'h16,
                 7'h17, 7'h17, 7'h10, 7'h13, 7'h13, 7'h14, 7'h14};
      pac_lo = '{7'h40, 7'h60, 7'h40, 7'h60, 7'h40, 7'h60, 7'h40, 7'h60,
                 7'h40, 7'h60, 7'h40, 7'h40, 7'h60, 7'h40, 7'h60};
    endfunction

    function logic [7:0] odd_byte(logic [6:0] b);
      int ones;
      ones = 0;
      for (int i = 0; i < 7; i++) ones += b[i];
      return {(ones % 2) == 0, b};
    endfunction

    function logic [15:0] code_pair(logic [6:0] hi, logic [6:0] lo);
      return {odd_byte(hi), odd_byte(lo)};
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        REG_CONTROL_HIGH: ctrl_hi = val;
        REG_RESUME_LOW:   rcl_lo  = val;
        REG_END_LOW:      eoc_lo  = val;
        REG_ERASE_LOW:    enm_lo  = val;
        default: ;
      endcase
    endfunction

    function void push(logic [15:0] word, logic last);
      caption_pair_t p;
      p.word = word;
      p.last = last;
      pairs_due.insert(pairs_due.size(), p);
    endfunction

    function int pending();
      return pairs_due.size();
    endfunction

    function void note_item(cmd_t cmd, logic [15:0] code, logic [3:0] row, logic [4:0] col);
      logic [3:0] r;
      logic [6:0] lo;
      logic [2:0] step;
      logic [6:0] raw;
      logic [7:0] b;
      case (cmd)
        CMD_START: begin
          r    = (row == 4'd0) ? 4'd1 : row;
          lo   = pac_lo[r - 1];
          step = col[4:2];
          if (step != 3'd0) lo = lo | INDENT_FLAG | {3'd0, step, 1'b0};
          // A held character is thrown away by a new cue.
          held      = 1'b0;
          held_byte = 8'h00;
          push(code_pair(ctrl_hi, enm_lo), 1'b0);
          push(code_pair(ctrl_hi, rcl_lo), 1'b0);
          push(code_pair(pac_hi[r - 1], lo), 1'b1);
        end
        CMD_CHAR: begin
          raw = (code < 16'h0020 || code > 16'h007F) ? CHAR_SPACE : code[6:0];
          b   = odd_byte(raw);
          if (held) begin
            push({held_byte, b}, 1'b1);
            held      = 1'b0;
            held_byte = 8'h00;
          end else begin
            held      = 1'b1;
            held_byte = b;
          end
        end
        CMD_END: begin
          if (held) push({held_byte, NULL_PAD}, 1'b0);
          held      = 1'b0;
          held_byte = 8'h00;
          push(code_pair(ctrl_hi, eoc_lo), 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_pair(logic [15:0] word, logic last);
      caption_pair_t due;
      if (pairs_due.size() == 0) begin
        report($sformatf("unexpected pair %h last %b", word, last));
        return;
      end
      due = pairs_due.pop_front();
      if (word !== due.word)
        report($sformatf("pair_word %h, expected %h", word, due.word));
      if (last !== due.last)
        report($sformatf("last_of_run %b, expected %b (pair %h)", last, due.last, due.word));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = CMD_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = REG_CONTROL_HIGH;
  logic [6:0]  cfg_data   = '0;

  pair_scoreboard sb;
  int in_gap_pct  = 30;
  int out_gap_pct = 30;
  bit quiet       = 1'b0;
  int out_hold    = 0;
  int idle_cycles = 0;

  cea608_popon_pair_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!quiet && out_hold == 0 && $urandom_range(0, 99) < out_gap_pct)
      out_hold = $urandom_range(1, 8);
    if (!quiet && out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pair(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("cea608_popon_pair_encoder_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(16'h20, 16'h7F));
    if (pick < 80) return 16'($urandom_range(0, 16'h1F));
    return 16'($urandom);
  endfunction

  task automatic send_item(cmd_t cmd, logic [15:0] code, logic [3:0] row, logic [4:0] col);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, col, row, code};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, code, row, col);
  endtask

  task automatic send_char();
    send_item(CMD_CHAR, rand_code(), 4'($urandom), 5'($urandom));
  endtask

  task automatic send_cue_start();
    send_item(CMD_START, 16'($urandom), 4'($urandom), 5'($urandom));
  endtask

  // Holds the sender off until every predicted pair has left the block, then
  // allows for a character item that is still being absorbed.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic program_regs(logic [6:0] ctl, logic [6:0] rcl, logic [6:0] eoc,
                              logic [6:0] enm);
    logic [6:0] vals [4];
    logic [1:0] idx [4];
    vals = '{ctl, rcl, eoc, enm};
    idx  = '{REG_CONTROL_HIGH, REG_RESUME_LOW, REG_END_LOW, REG_ERASE_LOW};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_captions(int target);
    int sent;
    int n;
    int pick;
    cmd_t cmd;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_cue_start();
        n = $urandom_range(0, 7);
        repeat (n) send_char();
        send_item(CMD_END, 16'($urandom), 4'($urandom), 5'($urandom));
        sent += n + 2;
      end else if (pick < 93) begin
        cmd = cmd_t'($urandom_range(0, 3));
        send_item(cmd, rand_code(), 4'($urandom), 5'($urandom));
        if (cmd != CMD_NONE) sent++;
      end else begin
        // A cue cut short by the next one.
        send_cue_start();
        n = $urandom_range(1, 3);
        repeat (n) send_char();
        sent += n + 1;
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset register values.
    send_item(CMD_START, 16'h0000, 4'd0,  5'd0);
    send_item(CMD_START, 16'hFFFF, 4'd15, 5'd31);
    send_item(CMD_START, 16'h0000, 4'd1,  5'd3);
    send_item(CMD_START, 16'h0000, 4'd11, 5'd4);
    send_item(CMD_CHAR,  16'h0000, 4'd0,  5'd0);
    send_item(CMD_CHAR,  16'h001F, 4'd0,  5'd0);
    send_item(CMD_CHAR,  16'h0020, 4'd0,  5'd0);
    send_item(CMD_CHAR,  16'h007F, 4'd0,  5'd0);
    send_item(CMD_CHAR,  16'h0080, 4'd0,  5'd0);
    send_item(CMD_CHAR,  16'hFFFF, 4'd15, 5'd31);
    send_item(CMD_CHAR,  16'h0041, 4'd0,  5'd0);
    send_item(CMD_END,   16'h0000, 4'd0,  5'd0);
    send_item(CMD_END,   16'hFFFF, 4'd15, 5'd31);
    send_item(CMD_CHAR,  16'h005A, 4'd0,  5'd0);
    send_item(CMD_START, 16'h0000, 4'd7,  5'd16);
    send_item(CMD_CHAR,  16'h0061, 4'd0,  5'd0);
    send_item(CMD_NONE,  16'hFFFF, 4'd15, 5'd31);
    send_item(CMD_CHAR,  16'h0062, 4'd0,  5'd0);
    send_item(CMD_END,   16'h0000, 4'd0,  5'd0);
    send_item(CMD_NONE,  16'h0000, 4'd0,  5'd0);
    send_item(CMD_END,   16'h0000, 4'd0,  5'd0);

    drain_results();
    program_regs(7'd0, 7'd0, 7'd0, 7'd0);
    in_gap_pct  = 30;
    out_gap_pct = 30;
    run_captions(90);

    drain_results();
    program_regs(7'd127, 7'd127, 7'd127, 7'd127);
    in_gap_pct  = 0;
    out_gap_pct = 40;
    run_captions(45);
    drain_results();
    run_captions(45);

    drain_results();
    program_regs(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    in_gap_pct  = 50;
    out_gap_pct = 0;
    run_captions(90);

    drain_results();
    program_regs(7'd127, 7'd0, 7'd127, 7'd0);
    in_gap_pct  = 20;
    out_gap_pct = 20;
    run_captions(90);

    drain_results();
    program_regs(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    quiet = 1'b1;
    run_captions(90);

    in_tvalid <= 1'b0;
    for (int i = 0; i < IDLE_LIMIT && sb.pending() > 0; i++) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.pending() > 0) sb.report($sformatf("%0d pairs never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("cea608_popon_pair_encoder_unit regression: pass");
    end else begin
      $display("cea608_popon_pair_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
